### rtl/srlbm_pkg.sv
// srlbm_pkg: constants, types and helpers for the stereo rms level/balance meter
// no dependencies
package srlbm_pkg;

    localparam int unsigned BufferDepthDefault = 256;
    localparam logic [16:0] SmoothReset = 17'd60948;
    localparam logic [16:0] DecayQ16    = 17'd64881;
    localparam logic [16:0] GrowthQ16   = 17'd13107;
    localparam logic [16:0] OneQ16      = 17'd65536;
    localparam logic signed [17:0] ScaleReset = 18'sd32768;
    localparam logic signed [17:0] ScaleLimit = 18'sd65536;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_L,
        ST_SQRT_L,
        ST_DIV_R,
        ST_SQRT_R,
        ST_DIV_M,
        ST_SQRT_M,
        ST_SMOOTH,
        ST_SCALE,
        ST_QUOT,
        ST_OUT
    } state_t;

    // result beat
    typedef struct packed {
        logic [14:0]        rms_left;
        logic [14:0]        rms_right;
        logic [14:0]        rms_mono;
        logic [14:0]        level_left_smoothed;
        logic [14:0]        level_right_smoothed;
        logic [14:0]        level_mono_smoothed;
        logic signed [15:0] balance_smoothed;
        logic signed [15:0] balance_scaled;
        logic [8:0]         samples_counted;
    } result_t;

endpackage

### rtl/srlbm_if.sv
// srlbm_if: valid/ready channel interfaces for the meter
// depends on srlbm_pkg
interface srlbm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_of_buffer;
    modport source (output valid, left_sample, right_sample, last_of_buffer, input ready);
    modport sink (input valid, left_sample, right_sample, last_of_buffer, output ready);
endinterface

interface srlbm_out_if;
    logic                valid;
    logic                ready;
    srlbm_pkg::result_t  data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface srlbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] smoothing_factor;
    modport source (output valid, smoothing_factor, input ready);
    modport sink (input valid, smoothing_factor, output ready);
endinterface

### rtl/stereo_rms_level_balance_meter.sv
// stereo_rms_level_balance_meter: top level, accumulators, sequencer, root and smoothing
// depends on srlbm_pkg, srlbm_if, srlbm_divider
//
// channel  dir  payload
// in_ch    in   left_sample, right_sample, last_of_buffer
// cfg_ch   in   smoothing_factor (17 bits)
// out_ch   out  result_t (nine fields)
//
// an unmarked beat is registered, then accumulated, and the input is ready again after that.
// a marked beat then runs the sequencer, which uses the shared 48-step divider (three
// means and the balance quotient) and the 16-step root loop; with a zero scale the
// quotient pass is skipped.
// the result sits in an output register; input beats keep flowing while it waits,
// and a following result holds the sequencer in its last state until it is taken.
// reset: async active low, clears accumulators, smoothed state and scale to 0.5.
module stereo_rms_level_balance_meter #(
    parameter int unsigned BUFFER_DEPTH = srlbm_pkg::BufferDepthDefault
) (
    input logic clk,
    input logic rst_n,
    srlbm_in_if.sink    in_ch,
    srlbm_cfg_if.sink   cfg_ch,
    srlbm_out_if.source out_ch
);
    localparam int CntW = $clog2(BUFFER_DEPTH + 1);
    localparam int SumW = 30 + CntW;

    srlbm_pkg::state_t state_reg, state_next;

    logic [16:0]     alpha_reg;
    logic [SumW-1:0] sum_l_reg, sum_r_reg;
    logic [CntW-1:0] cnt_reg;
    logic            last_reg;
    logic            acc_reg;
    logic signed [15:0] hl_reg, hr_reg;

    logic [14:0] rl_reg, rr_reg, rm_reg;
    logic [14:0] sl_reg, sr_reg, sm_reg;
    logic signed [15:0] sb_reg;
    logic signed [17:0] scale_reg;
    logic signed [15:0] sc_reg;

    // root unit
    logic [31:0] rv_reg;
    logic [15:0] rres_reg;
    logic [4:0]  rstep_reg;
    logic [3:0]  sub_reg;

    logic        div_start;
    logic [47:0] div_a, div_b, div_q;
    logic        div_done;

    logic              out_valid_reg;
    srlbm_pkg::result_t out_reg;
    logic              out_load;

    srlbm_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == srlbm_pkg::ST_IDLE) && !acc_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // result register free this cycle
    assign out_load = (state_reg == srlbm_pkg::ST_OUT) && (!out_valid_reg || out_ch.ready);

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= srlbm_pkg::SmoothReset;
        else if (cfg_ch.valid)
            alpha_reg <= cfg_ch.smoothing_factor;
    end

    // squares of the halved samples
    logic signed [31:0] sq_l, sq_r;
    assign sq_l = 32'(hl_reg) * 32'(hl_reg);
    assign sq_r = 32'(hr_reg) * 32'(hr_reg);

    // smoothing combinational helper: one multiply pair, rounded
    logic [16:0] a_eff;
    logic [16:0] a_inv;
    assign a_eff = (alpha_reg > srlbm_pkg::OneQ16) ? srlbm_pkg::OneQ16 : alpha_reg;
    assign a_inv = 17'(srlbm_pkg::OneQ16 - a_eff);

    logic signed [16:0] sm_old, sm_new;
    logic signed [40:0] sm_sum;
    logic signed [24:0] sm_res;
    logic signed [15:0] bal;
    assign bal = $signed({1'b0, rr_reg}) - $signed({1'b0, rl_reg});

    always_comb
    begin
        case (sub_reg[1:0])
            2'd0:    begin sm_old = {2'b0, sl_reg}; sm_new = {2'b0, rl_reg}; end
            2'd1:    begin sm_old = {2'b0, sr_reg}; sm_new = {2'b0, rr_reg}; end
            2'd2:    begin sm_old = {2'b0, sm_reg}; sm_new = {2'b0, rm_reg}; end
            default: begin sm_old = 17'(sb_reg);   sm_new = 17'(bal);       end
        endcase
        sm_sum = $signed({1'b0, a_eff}) * sm_old + $signed({1'b0, a_inv}) * sm_new
                 + 41'sd32768;
        sm_res = sm_sum[40:16];
    end

    // scale update pieces
    logic signed [35:0] dec_p;
    logic signed [17:0] dec_s;
    logic signed [33:0] gro_p;
    logic signed [18:0] gro_s;
    logic signed [18:0] grown;
    logic [17:0] abs_scale, abs_bal;
    always_comb
    begin
        dec_p = scale_reg * $signed({1'b0, srlbm_pkg::DecayQ16}) + 36'sd32768;
        dec_s = dec_p[33:16];
        gro_p = bal * $signed({1'b0, srlbm_pkg::GrowthQ16}) + 34'sd32768;
        gro_s = 19'($signed(gro_p[33:16]));
        abs_scale = dec_s[17] ? 18'(-dec_s) : dec_s;
        abs_bal   = bal[15] ? 18'(-bal) : 18'(bal);
        grown = 19'(dec_s);
        if (abs_bal > abs_scale)
            grown = 19'(dec_s) + gro_s;
        if (grown > 19'(srlbm_pkg::ScaleLimit))
            grown = 19'(srlbm_pkg::ScaleLimit);
        if (grown < -19'(srlbm_pkg::ScaleLimit))
            grown = -19'(srlbm_pkg::ScaleLimit);
    end

    logic [17:0] absb, absd;
    assign absb = sb_reg[15] ? 18'(-sb_reg) : 18'(sb_reg);
    assign absd = scale_reg[17] ? 18'(-scale_reg) : scale_reg;

    // division operands
    always_comb
    begin
        div_a = '0;
        div_b = 48'd1;
        case (state_reg)
            srlbm_pkg::ST_DIV_L: begin div_a = 48'(sum_l_reg); div_b = 48'(cnt_reg); end
            srlbm_pkg::ST_DIV_R: begin div_a = 48'(sum_r_reg); div_b = 48'(cnt_reg); end
            srlbm_pkg::ST_DIV_M:
            begin
                div_a = 48'(sum_l_reg) + 48'(sum_r_reg);
                div_b = {47'(cnt_reg), 1'b0};
            end
            srlbm_pkg::ST_QUOT:
            begin
                div_a = {17'b0, absb, 13'b0} + 48'(absd);
                div_b = {29'b0, absd, 1'b0};
            end
            default: ;
        endcase
    end

    logic started_reg;
    assign div_start = !started_reg && (state_reg == srlbm_pkg::ST_DIV_L
        || state_reg == srlbm_pkg::ST_DIV_R || state_reg == srlbm_pkg::ST_DIV_M
        || state_reg == srlbm_pkg::ST_QUOT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srlbm_pkg::ST_IDLE:   if (acc_reg && last_reg) state_next = srlbm_pkg::ST_DIV_L;
            srlbm_pkg::ST_DIV_L:  if (div_done) state_next = srlbm_pkg::ST_SQRT_L;
            srlbm_pkg::ST_SQRT_L: if (rstep_reg == 5'd16) state_next = srlbm_pkg::ST_DIV_R;
            srlbm_pkg::ST_DIV_R:  if (div_done) state_next = srlbm_pkg::ST_SQRT_R;
            srlbm_pkg::ST_SQRT_R: if (rstep_reg == 5'd16) state_next = srlbm_pkg::ST_DIV_M;
            srlbm_pkg::ST_DIV_M:  if (div_done) state_next = srlbm_pkg::ST_SQRT_M;
            srlbm_pkg::ST_SQRT_M: if (rstep_reg == 5'd16) state_next = srlbm_pkg::ST_SMOOTH;
            srlbm_pkg::ST_SMOOTH: if (sub_reg == 4'd3) state_next = srlbm_pkg::ST_SCALE;
            srlbm_pkg::ST_SCALE:  state_next = (grown == 19'sd0) ? srlbm_pkg::ST_OUT
                                                                 : srlbm_pkg::ST_QUOT;
            srlbm_pkg::ST_QUOT:   if (div_done) state_next = srlbm_pkg::ST_OUT;
            srlbm_pkg::ST_OUT:    if (out_load) state_next = srlbm_pkg::ST_IDLE;
            default:              state_next = srlbm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= srlbm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // root bit test, restoring form on 32-bit radicand
    logic [15:0] rcand;
    logic [31:0] rsq;
    assign rcand = rres_reg | (16'h8000 >> rstep_reg[3:0]);
    assign rsq = rcand * rcand;

    logic [15:0] qsat;
    logic signed [15:0] scaled;
    logic neg;
    always_comb
    begin
        qsat = (div_q > 48'd32768) ? 16'h8000 : div_q[15:0];
        neg = sb_reg[15] != scale_reg[17];
        if (neg)
            scaled = 16'(-$signed({1'b0, qsat}));
        else
            scaled = (qsat[15]) ? 16'sh7fff : $signed(qsat);
    end

    // datapath and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 1'b0;
            last_reg      <= 1'b0;
            hl_reg        <= '0;
            hr_reg        <= '0;
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            cnt_reg       <= '0;
            rl_reg        <= '0;
            rr_reg        <= '0;
            rm_reg        <= '0;
            sl_reg        <= '0;
            sr_reg        <= '0;
            sm_reg        <= '0;
            sb_reg        <= '0;
            sc_reg        <= '0;
            scale_reg     <= srlbm_pkg::ScaleReset;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            started_reg   <= 1'b0;
            rv_reg        <= '0;
            rres_reg      <= '0;
            rstep_reg     <= '0;
            sub_reg       <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                acc_reg  <= 1'b1;
                last_reg <= in_ch.last_of_buffer;
                hl_reg   <= in_ch.left_sample >>> 1;
                hr_reg   <= in_ch.right_sample >>> 1;
            end
            // accumulate step for each accepted beat, until BUFFER_DEPTH beats are counted
            if (acc_reg)
            begin
                acc_reg <= 1'b0;
                if (cnt_reg < CntW'(BUFFER_DEPTH))
                begin
                    sum_l_reg <= sum_l_reg + SumW'($unsigned(sq_l));
                    sum_r_reg <= sum_r_reg + SumW'($unsigned(sq_r));
                    cnt_reg   <= cnt_reg + CntW'(1);
                end
            end
            started_reg <= div_start ? 1'b1 : (div_done ? 1'b0 : started_reg);
            case (state_reg)
                srlbm_pkg::ST_DIV_L, srlbm_pkg::ST_DIV_R, srlbm_pkg::ST_DIV_M:
                begin
                    if (div_done)
                    begin
                        rv_reg    <= div_q[31:0];
                        rres_reg  <= '0;
                        rstep_reg <= '0;
                    end
                end
                srlbm_pkg::ST_SQRT_L, srlbm_pkg::ST_SQRT_R, srlbm_pkg::ST_SQRT_M:
                begin
                    if (rstep_reg == 5'd16)
                    begin
                        if (state_reg == srlbm_pkg::ST_SQRT_L) rl_reg <= rres_reg[14:0];
                        else if (state_reg == srlbm_pkg::ST_SQRT_R) rr_reg <= rres_reg[14:0];
                        else rm_reg <= rres_reg[14:0];
                        sub_reg <= '0;
                    end
                    else
                    begin
                        if (rsq <= rv_reg)
                            rres_reg <= rcand;
                        rstep_reg <= rstep_reg + 5'd1;
                    end
                end
                srlbm_pkg::ST_SMOOTH:
                begin
                    case (sub_reg[1:0])
                        2'd0:    sl_reg <= sm_res[14:0];
                        2'd1:    sr_reg <= sm_res[14:0];
                        2'd2:    sm_reg <= sm_res[14:0];
                        default: sb_reg <= sm_res[15:0];
                    endcase
                    sub_reg <= sub_reg + 4'd1;
                end
                srlbm_pkg::ST_SCALE:
                begin
                    scale_reg <= grown[17:0];
                    if (grown == 19'sd0)
                        sc_reg <= sb_reg[15] ? 16'sh8000 :
                            ((sb_reg == 16'sd0) ? 16'sd0 : 16'sd32767);
                end
                srlbm_pkg::ST_QUOT:
                    if (div_done)
                        sc_reg <= scaled;
                srlbm_pkg::ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg.rms_left             <= rl_reg;
                        out_reg.rms_right            <= rr_reg;
                        out_reg.rms_mono             <= rm_reg;
                        out_reg.level_left_smoothed  <= sl_reg;
                        out_reg.level_right_smoothed <= sr_reg;
                        out_reg.level_mono_smoothed  <= sm_reg;
                        out_reg.balance_smoothed     <= sb_reg;
                        out_reg.balance_scaled       <= sc_reg;
                        out_reg.samples_counted      <= 9'(cnt_reg);
                        sum_l_reg <= '0;
                        sum_r_reg <= '0;
                        cnt_reg   <= '0;
                        last_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/srlbm_divider.sv
// srlbm_divider: shared restoring divider, one quotient bit per cycle
// no dependencies
module srlbm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [47:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [47:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] trial;

    // load on start, else one restoring step while busy
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[47]};
        done      = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 48'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial[47:0];
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = quo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end
endmodule

### dv/tb_top.sv
// tb_top: self-checking bench for the stereo rms level/balance meter
// depends on srlbm_pkg, srlbm_if and the meter rtl
// a built-in predictor computes each buffer result; a driver feeds the pairs and a monitor checks the results
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    srlbm_in_if  in_ch ();
    srlbm_cfg_if cfg_ch ();
    srlbm_out_if out_ch ();

    stereo_rms_level_balance_meter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg_ch (cfg_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // predictor state
    longint unsigned acc_l, acc_r;
    int unsigned     n_pairs;
    longint          lvl_l, lvl_r, lvl_m, bal_s, scale;
    longint          weight;

    pair_t                pending_pairs[$];
    srlbm_pkg::result_t   expected_levels[$];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_off = 1'b0;
    bit       hold_req = 1'b0;
    int       hold_cnt = 0;
    int       mismatches = 0;
    int       cycles = 0;
    bit       cfg_done;

    function automatic longint rnd16(longint num);
        longint q;
        q = (num + 32768) >>> 16;
        return q;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint ease(longint old, longint x);
        return rnd16(weight * old + (65536 - weight) * x);
    endfunction

    // model one accepted pair
    task automatic predict_pair(pair_t p);
        longint hl, hr, rl, rr, rm, bal, sc, absb, abss;
        longint unsigned q, num, den;
        srlbm_pkg::result_t res;
        if (n_pairs < srlbm_pkg::BufferDepthDefault)
        begin
            hl = longint'(p.left) >>> 1;
            hr = longint'(p.right) >>> 1;
            acc_l += longint'(hl * hl);
            acc_r += longint'(hr * hr);
            n_pairs++;
        end
        if (!p.last) return;
        rl = int_sqrt(acc_l / n_pairs);
        rr = int_sqrt(acc_r / n_pairs);
        rm = int_sqrt((acc_l + acc_r) / (2 * n_pairs));
        lvl_l = ease(lvl_l, rl);
        lvl_r = ease(lvl_r, rr);
        lvl_m = ease(lvl_m, rm);
        bal = rr - rl;
        bal_s = ease(bal_s, bal);
        scale = rnd16(scale * longint'(srlbm_pkg::DecayQ16));
        absb = bal < 0 ? -bal : bal;
        abss = scale < 0 ? -scale : scale;
        if (absb > abss) scale += rnd16(bal * longint'(srlbm_pkg::GrowthQ16));
        if (scale > 65536) scale = 65536;
        if (scale < -65536) scale = -65536;
        if (scale == 0)
            sc = bal_s > 0 ? 32767 : (bal_s < 0 ? -32768 : 0);
        else
        begin
            num = (bal_s < 0 ? -bal_s : bal_s) * 4096;
            den = scale < 0 ? -scale : scale;
            q = (2 * num + den) / (2 * den);
            if (q > 32768) q = 32768;
            sc = ((bal_s < 0) != (scale < 0)) ? -longint'(q) : longint'(q);
            if (sc > 32767) sc = 32767;
        end
        res.rms_left             = rl[14:0];
        res.rms_right            = rr[14:0];
        res.rms_mono             = rm[14:0];
        res.level_left_smoothed  = lvl_l[14:0];
        res.level_right_smoothed = lvl_r[14:0];
        res.level_mono_smoothed  = lvl_m[14:0];
        res.balance_smoothed     = bal_s[15:0];
        res.balance_scaled       = sc[15:0];
        res.samples_counted      = n_pairs[8:0];
        expected_levels.push_back(res);
        acc_l = 0;
        acc_r = 0;
        n_pairs = 0;
    endtask

    // driver: offer queued pairs, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.left_sample <= '0;
            in_ch.right_sample <= '0;
            in_ch.last_of_buffer <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid) predict_pair({in_ch.left_sample, in_ch.right_sample,
                                           in_ch.last_of_buffer});
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.left_sample <= pending_pairs[0].left;
                in_ch.right_sample <= pending_pairs[0].right;
                in_ch.last_of_buffer <= pending_pairs[0].last;
                void'(pending_pairs.pop_front());
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver ready with random stalls and hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && $urandom_range(99) >= recv_stall_pct;
    end

    // long receiver hold-off, counted in cycles here
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            if (hold_cnt >= 2000)
                hold_off <= 1'b0;
            else
                hold_cnt <= hold_cnt + 1;
        end
        else if (hold_req && hold_cnt == 0)
            hold_off <= 1'b1;
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", out_ch.data);
            end
            else
            begin
                if (out_ch.data !== expected_levels[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_levels[0], out_ch.data);
                end
                void'(expected_levels.pop_front());
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_pair(int l, int r, bit last);
        pair_t p;
        p.left = l[15:0];
        p.right = r[15:0];
        p.last = last;
        pending_pairs.push_back(p);
    endtask

    task automatic add_buffer(int len, int mode);
        int l, r;
        for (int i = 0; i < len; i++)
        begin
            l = $urandom_range(65535) - 32768;
            r = $urandom_range(65535) - 32768;
            if (mode == 1) r = r / 16;
            if (mode == 2) l = l / 16;
            add_pair(l, r, i == len - 1);
        end
    endtask

    task automatic drain();
        wait (pending_pairs.size() == 0 && !in_ch.valid && expected_levels.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_weight(logic [16:0] w);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.smoothing_factor <= w;
        cfg_done = 0;
        while (!cfg_done)
        begin
            @(posedge clk);
            if (cfg_ch.ready) cfg_done = 1;
        end
        cfg_ch.valid <= 1'b0;
        weight = w > 65536 ? 65536 : longint'(w);
    endtask

    initial
    begin
        acc_l = 0; acc_r = 0; n_pairs = 0;
        lvl_l = 0; lvl_r = 0; lvl_m = 0; bal_s = 0;
        scale = longint'(srlbm_pkg::ScaleReset);
        weight = longint'(srlbm_pkg::SmoothReset);
        cfg_ch.valid = 1'b0;
        cfg_ch.smoothing_factor = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, single pair, one-sided, silent, overflow
        add_pair(-32768, 32767, 1'b1);
        add_pair(32767, -32768, 1'b1);
        add_pair(0, 0, 1'b1);
        add_pair(-1, 1, 1'b0);
        add_pair(1, -1, 1'b1);
        add_pair(-32768, 0, 1'b1);
        add_pair(0, -32768, 1'b1);
        add_pair(0, 0, 1'b0);
        add_pair(0, 0, 1'b1);
        add_pair(-21846, 21845, 1'b1);
        add_pair(21845, -21846, 1'b1);
        drain();
        for (int i = 0; i < 260; i++) add_pair(-32768, 32767, i == 259);
        drain();

        // smoothing weight sweep incl. extremes and above one
        write_weight(17'd0);
        for (int i = 0; i < 10; i++) add_buffer($urandom_range(1, 4), i % 3);
        drain();
        write_weight(17'h1FFFF);
        for (int i = 0; i < 10; i++) add_buffer($urandom_range(1, 4), i % 3);
        drain();
        write_weight(17'd65536);
        add_buffer(3, 1);
        drain();
        write_weight(17'd32768);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 52 : (ph == 3 ? 29 : 0);
            recv_stall_pct = (ph == 2) ? 52 : (ph == 3 ? 29 : 0);
            for (int i = 0; i < 9; i++)
                add_buffer($urandom_range(1, 5), $urandom_range(2));
            if (ph == 2)
                hold_req = 1'b1;
            drain();
            if (ph == 1) write_weight(17'd60948);
        end
        write_weight(17'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 10; i++) add_buffer($urandom_range(1, 3), i % 3);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
